/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, switched off while reset is asserted.
`define FAC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked property that also holds across reset.
`define FAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/fac_pkg.sv */
package fac_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int NUM_ENTRIES = 16;
    localparam int IDX_W       = 4;
    localparam int NUM_PLANES  = 6;
    localparam int NUM_AXES    = 3;
    localparam int NUM_COEFS   = 4;

    // Plane coefficient: sum or difference of two entries.
    localparam int COEF_W = DATA_WIDTH + 1;
    // Exact coefficient times coordinate.
    localparam int PROD_W = COEF_W + DATA_WIDTH;
    // Plane constant aligned to the product fraction.
    localparam int CONST_W = COEF_W + FRAC_BITS;
    // Accumulator: the widest term plus two bits of growth for four terms.
    localparam int ACC_W = ((PROD_W > CONST_W) ? PROD_W : CONST_W) + 2;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic signed [COEF_W-1:0]     t_coef;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [ACC_W-1:0]      t_acc;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } t_op;

    // Per-stage load enables handed to the plane datapaths.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

/* sv/frustum_aabb_cull_unit.sv */
// Frustum culling of axis-aligned boxes against a stored view-projection matrix.
// One input channel (i_valid / o_ready) carries two kinds of transaction. A load
// (operation 0) writes one of the 16 matrix entries, column-major, and yields no
// result. A test (operation 1) carries the min and max corners of a box and
// yields one result transaction on the output channel (o_valid / i_ready):
// o_inside_res is 0 when the box lies fully outside one of the six planes.
// A test sees every load accepted before it, including one in the cycle before.
// Throughput is one transaction per cycle while the receiver does not stall;
// the four register stages (plane coefficients, products, partial sums, final
// sum and sign) each hold an item. When the receiver stalls, each stage holds
// its item and the stage before it keeps filling, so bubbles are squeezed out;
// o_ready drops only when all four stages are full. Synchronous reset clears
// the matrix to zero and empties the pipeline.
`include "assert_macros.svh"

module frustum_aabb_cull_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_operation,
    input  logic [fac_pkg::IDX_W-1:0]   i_matrix_index,
    input  fac_pkg::t_data              i_matrix_value,
    input  fac_pkg::t_data              i_min_x,
    input  fac_pkg::t_data              i_min_y,
    input  fac_pkg::t_data              i_min_z,
    input  fac_pkg::t_data              i_max_x,
    input  fac_pkg::t_data              i_max_y,
    input  fac_pkg::t_data              i_max_z,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_inside_res
);
    import fac_pkg::*;

    // Stage valid bits travel with the data.
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic w_accept, w_test, w_load;
    t_stage_en w_en;

    t_data w_lo [NUM_AXES];
    t_data w_hi [NUM_AXES];
    t_coef s1_coef [NUM_PLANES][NUM_COEFS];
    t_data s1_lo [NUM_AXES];
    t_data s1_hi [NUM_AXES];
    logic [NUM_PLANES-1:0] w_pass;

    // A stage may take a new item when it is empty or its item moves on.
    assign w_rdy4 = !r_v4 || i_ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign o_ready  = w_rdy1;
    assign w_accept = i_valid && w_rdy1;
    assign w_test   = w_accept && (i_operation == OP_TEST);
    assign w_load   = w_accept && (i_operation == OP_LOAD);

    assign w_en.s2 = w_rdy2 && r_v1;
    assign w_en.s3 = w_rdy3 && r_v2;
    assign w_en.s4 = w_rdy4 && r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= w_test;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    assign w_lo[0] = i_min_x;
    assign w_lo[1] = i_min_y;
    assign w_lo[2] = i_min_z;
    assign w_hi[0] = i_max_x;
    assign w_hi[1] = i_max_y;
    assign w_hi[2] = i_max_z;

    // Stage one: matrix storage and the six plane coefficient sets.
    fac_plane_setup u_setup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (w_load),
        .i_idx     (i_matrix_index),
        .i_value   (i_matrix_value),
        .i_capture (w_test),
        .i_lo      (w_lo),
        .i_hi      (w_hi),
        .o_coef    (s1_coef),
        .o_lo      (s1_lo),
        .o_hi      (s1_hi)
    );

    // Stages two to four: one datapath per plane.
    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        fac_plane_eval u_eval (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_coef (s1_coef[p]),
            .i_lo   (s1_lo),
            .i_hi   (s1_hi),
            .o_pass (w_pass[p])
        );
    end

    assign o_valid      = r_v4;
    assign o_inside_res = &w_pass;

    // A load never occupies a pipeline stage.
    `FAC_ASSERT(a_load_no_slot, i_clk, i_rst_n, w_load |=> !r_v1, "load entered pipeline")
    // An accepted test always lands in stage one.
    `FAC_ASSERT(a_test_lands, i_clk, i_rst_n, w_test |=> r_v1, "accepted test was dropped")
    // Back-pressure reaches the input only when every stage is occupied.
    `FAC_ASSERT(a_full_stall, i_clk, i_rst_n, !o_ready |-> (r_v1 && r_v2 && r_v3 && r_v4), "stall with empty stage")
    // Reset empties the output stage.
    `FAC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

/* sv/fac_plane_setup.sv */
module fac_plane_setup (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_we,
    input  logic [fac_pkg::IDX_W-1:0] i_idx,
    input  fac_pkg::t_data            i_value,
    input  logic                      i_capture,
    input  fac_pkg::t_data            i_lo [fac_pkg::NUM_AXES],
    input  fac_pkg::t_data            i_hi [fac_pkg::NUM_AXES],
    output fac_pkg::t_coef            o_coef [fac_pkg::NUM_PLANES][fac_pkg::NUM_COEFS],
    output fac_pkg::t_data            o_lo [fac_pkg::NUM_AXES],
    output fac_pkg::t_data            o_hi [fac_pkg::NUM_AXES]
);
    import fac_pkg::*;

    t_data r_matrix [NUM_ENTRIES];
    t_coef r_coef   [NUM_PLANES][NUM_COEFS];
    t_coef n_coef   [NUM_PLANES][NUM_COEFS];
    t_data r_lo     [NUM_AXES];
    t_data r_hi     [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                r_matrix[e] <= '0;
            end
        end else if (i_we) begin
            r_matrix[i_idx] <= i_value;
        end
    end

    // Planes come in pairs per row: the fourth row plus, then minus, that row.
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int k = 0; k < NUM_COEFS; k++) begin
                if ((p % 2) == 1) begin
                    n_coef[p][k] = COEF_W'(r_matrix[k*4 + 3]) - COEF_W'(r_matrix[k*4 + p/2]);
                end else begin
                    n_coef[p][k] = COEF_W'(r_matrix[k*4 + 3]) + COEF_W'(r_matrix[k*4 + p/2]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_coef <= n_coef;
            r_lo   <= i_lo;
            r_hi   <= i_hi;
        end
    end

    assign o_coef = r_coef;
    assign o_lo   = r_lo;
    assign o_hi   = r_hi;

endmodule

/* sv/fac_plane_eval.sv */
module fac_plane_eval (
    input  logic               i_clk,
    input  fac_pkg::t_stage_en i_en,
    input  fac_pkg::t_coef     i_coef [fac_pkg::NUM_COEFS],
    input  fac_pkg::t_data     i_lo [fac_pkg::NUM_AXES],
    input  fac_pkg::t_data     i_hi [fac_pkg::NUM_AXES],
    output logic               o_pass
);
    import fac_pkg::*;

    t_prod r_prod [NUM_AXES];
    t_prod n_prod [NUM_AXES];
    t_acc  r_const;
    t_acc  r_sum_a;
    t_acc  r_sum_b;
    logic  r_pass;
    t_acc  w_total;

    // The positive vertex takes the max corner unless the coefficient is negative.
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            if (i_coef[k][COEF_W-1]) begin
                n_prod[k] = PROD_W'(i_coef[k]) * PROD_W'(i_lo[k]);
            end else begin
                n_prod[k] = PROD_W'(i_coef[k]) * PROD_W'(i_hi[k]);
            end
        end
    end

    assign w_total = r_sum_a + r_sum_b;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prod  <= n_prod;
            r_const <= ACC_W'(i_coef[NUM_AXES]) <<< FRAC_BITS;
        end
        if (i_en.s3) begin
            r_sum_a <= ACC_W'(r_prod[0]) + ACC_W'(r_prod[1]);
            r_sum_b <= ACC_W'(r_prod[2]) + r_const;
        end
        if (i_en.s4) begin
            r_pass <= ~w_total[ACC_W-1];
        end
    end

    assign o_pass = r_pass;

endmodule
